@@ sv/prq_pkg.sv @@
// types and codes shared by the priority run queue scheduler
package prq_pkg;

    // action codes
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_PICK    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // slot field width caps the number of reachable slots
    localparam int SLOT_FIELD_SLOTS = 256;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] task_slot;
        logic [1:0] priority_req;
        logic       runnable;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       picked_valid;
        logic [7:0] picked_slot;
        logic [1:0] picked_priority;
        logic [8:0] queued_count;
        logic [3:0] nonempty_mask;
    } res_t;

endpackage

@@ sv/prq_ram.sv @@
// single write port, single read port ram with registered read data
module prq_ram
    #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/priority_run_queue_scheduler.sv @@
// top level of the priority run queue scheduler: control, queue registers and link rams
//
// usage
//   cmd channel (cmd_valid / cmd_ready / cmd) takes one beat per action:
//   enqueue a ready slot at the tail of its level, remove a slot from
//   anywhere in its level, or pick the head of the highest non-empty level
//   res channel (res_valid / res_ready / res) returns exactly one beat per
//   command with status, picked slot and level, queued count and the
//   per-level non-empty mask as they stand after the action
//   timing: the command beat loads the command registers, and the result is
//   registered when the command completes; the block takes no new command
//   until the last one has completed; the first step reads the
//   slot's link entries from the synchronous link rams, the second does the
//   read-modify-write of the neighbor links and queue registers
//   a finished result may wait in the output register while the next
//   command is accepted; that command then holds in its second step,
//   with no state written, until the output register frees up
//   reset clears the queued flags, non-empty mask, count and handshake
//   state; link rams and head/tail registers are not cleared and are only
//   read for queued slots or non-empty levels
module priority_run_queue_scheduler
    import prq_pkg::*;
    #(
    parameter int TASK_SLOTS      = 256,
    parameter int PRIORITY_LEVELS = 4
    )
    (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
    );

    // only slots addressable by the 8-bit slot field are ever used
    localparam int NSLOT = (TASK_SLOTS < SLOT_FIELD_SLOTS) ? TASK_SLOTS : SLOT_FIELD_SLOTS;
    localparam int SW    = $clog2(NSLOT);
    localparam int LW    = $clog2(PRIORITY_LEVELS);
    localparam int CW    = $clog2(NSLOT + 1);

    typedef enum logic {S_IDLE, S_EXEC} state_t;
    typedef enum logic [1:0] {OP_NONE, OP_APPEND, OP_UNLINK} op_t;

    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    logic [1:0]                 status_reg, status_next;
    logic                       pick_reg, pick_next;
    logic [SW-1:0]              slot_reg, slot_next;
    logic [LW-1:0]              lvl_reg, lvl_next;
    logic [NSLOT-1:0]           queued_reg, queued_next;
    logic [PRIORITY_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       res_valid_reg, res_valid_next;
    res_t                       res_reg, res_next;

    // per-level head and tail, read at one level per cycle
    logic [SW-1:0] head_reg [PRIORITY_LEVELS];
    logic [SW-1:0] tail_reg [PRIORITY_LEVELS];

    logic          accept;
    logic          commit;
    logic [LW-1:0] top_lvl;
    logic          any_nonempty;
    logic [LW-1:0] rd_lvl;
    logic [SW-1:0] head_rd, tail_rd;
    logic [LW-1:0] cur_lvl;
    logic [SW-1:0] slot_in;
    logic          slot_in_range;
    logic [LW-1:0] req_lvl;

    // link ram ports
    logic          nxt_we, prv_we, lvl_we;
    logic [SW-1:0] nxt_waddr, prv_waddr;
    logic [SW-1:0] nxt_wdata, prv_wdata;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] nx_rd, pv_rd;
    logic [LW-1:0] lvl_rd;

    // unlink decode
    logic is_head, is_tail;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    // exec state completes only when the output register is free
    assign commit    = (state_reg == S_EXEC) && (!res_valid_reg || res_ready);

    assign slot_in       = cmd.task_slot[SW-1:0];
    assign slot_in_range = (32'(cmd.task_slot) < NSLOT);
    assign req_lvl       = (32'(cmd.priority_req) >= PRIORITY_LEVELS)
                         ? LW'(PRIORITY_LEVELS - 1) : LW'(cmd.priority_req);

    // highest non-empty level
    always_comb
    begin
        top_lvl      = '0;
        any_nonempty = 1'b0;
        for (int p = 0; p < PRIORITY_LEVELS; p++)
        begin
            if (nonempty_reg[p])
            begin
                top_lvl      = LW'(p);
                any_nonempty = 1'b1;
            end
        end
    end

    // remove takes its level from the level ram, enqueue from the command, pick from the highest non-empty level
    assign cur_lvl = (op_reg == OP_UNLINK && !pick_reg) ? lvl_rd : lvl_reg;
    assign rd_lvl  = (state_reg == S_IDLE) ? top_lvl : cur_lvl;
    assign head_rd = head_reg[rd_lvl];
    assign tail_rd = tail_reg[rd_lvl];

    // pick reads the links of the current head, remove those of the given slot
    assign rd_addr = (cmd.action == ACT_PICK) ? head_rd : slot_in;

    assign is_head = (head_rd == slot_reg);
    assign is_tail = (tail_rd == slot_reg);

    // link ram writes
    always_comb
    begin
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        lvl_we    = 1'b0;
        nxt_waddr = tail_rd;
        nxt_wdata = slot_reg;
        prv_waddr = slot_reg;
        prv_wdata = tail_rd;
        if (commit)
        begin
            unique case (op_reg)
                OP_APPEND:
                begin
                    // link behind the old tail when the level already holds slots
                    nxt_we = nonempty_reg[cur_lvl];
                    prv_we = nonempty_reg[cur_lvl];
                    lvl_we = 1'b1;
                end
                OP_UNLINK:
                begin
                    // slot in the middle: bridge its neighbors
                    if (!is_head && !is_tail)
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = pv_rd;
                        nxt_wdata = nx_rd;
                        prv_we    = 1'b1;
                        prv_waddr = nx_rd;
                        prv_wdata = pv_rd;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    prq_ram
        #(
        .DEPTH (NSLOT),
        .WIDTH (SW)
        )
    u_next_ram
        (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (nx_rd)
        );

    prq_ram
        #(
        .DEPTH (NSLOT),
        .WIDTH (SW)
        )
    u_prev_ram
        (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (pv_rd)
        );

    prq_ram
        #(
        .DEPTH (NSLOT),
        .WIDTH (LW)
        )
    u_level_ram
        (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (slot_reg),
        .wdata (cur_lvl),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (lvl_rd)
        );

    // control and result next values
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        pick_next      = pick_reg;
        slot_next      = slot_reg;
        lvl_next       = lvl_reg;
        queued_next    = queued_reg;
        nonempty_next  = nonempty_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (accept)
        begin
            // classify the command against the queued flags and the non-empty mask
            state_next  = S_EXEC;
            op_next     = OP_NONE;
            status_next = ST_OK;
            pick_next   = 1'b0;
            slot_next   = slot_in;
            lvl_next    = req_lvl;
            unique case (cmd.action)
                ACT_ENQUEUE:
                begin
                    priority if (!cmd.runnable)
                    begin
                        status_next = ST_NOT_READY;
                    end
                    else if (!slot_in_range || queued_reg[slot_in])
                    begin
                        status_next = ST_BAD_SLOT;
                    end
                    else
                    begin
                        op_next = OP_APPEND;
                    end
                end
                ACT_REMOVE:
                begin
                    if (!slot_in_range || !queued_reg[slot_in])
                    begin
                        status_next = ST_BAD_SLOT;
                    end
                    else
                    begin
                        op_next = OP_UNLINK;
                    end
                end
                ACT_PICK:
                begin
                    pick_next = 1'b1;
                    slot_next = head_rd;
                    lvl_next  = top_lvl;
                    if (any_nonempty)
                    begin
                        op_next = OP_UNLINK;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (commit)
        begin
            state_next = S_IDLE;
            unique case (op_reg)
                OP_APPEND:
                begin
                    nonempty_next[cur_lvl] = 1'b1;
                    queued_next[slot_reg]  = 1'b1;
                    count_next             = count_reg + CW'(1);
                end
                OP_UNLINK:
                begin
                    if (is_head && is_tail)
                    begin
                        nonempty_next[cur_lvl] = 1'b0;
                    end
                    queued_next[slot_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase

            res_valid_next           = 1'b1;
            res_next.status          = status_reg;
            res_next.picked_valid    = pick_reg && (op_reg == OP_UNLINK);
            res_next.picked_slot     = (pick_reg && op_reg == OP_UNLINK) ? 8'(slot_reg) : 8'd0;
            res_next.picked_priority = (pick_reg && op_reg == OP_UNLINK) ? 2'(cur_lvl) : 2'd0;
            res_next.queued_count    = 9'(count_next);
            res_next.nonempty_mask   = 4'(nonempty_next);
        end
    end

    // state machine, queue bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            status_reg    <= ST_OK;
            pick_reg      <= 1'b0;
            slot_reg      <= '0;
            lvl_reg       <= '0;
            queued_reg    <= '0;
            nonempty_reg  <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            status_reg    <= status_next;
            pick_reg      <= pick_next;
            slot_reg      <= slot_next;
            lvl_reg       <= lvl_next;
            queued_reg    <= queued_next;
            nonempty_reg  <= nonempty_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // head and tail updates; undefined until first written
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            unique case (op_reg)
                OP_APPEND:
                begin
                    if (!nonempty_reg[cur_lvl])
                    begin
                        head_reg[cur_lvl] <= slot_reg;
                    end
                    tail_reg[cur_lvl] <= slot_reg;
                end
                OP_UNLINK:
                begin
                    priority if (is_head && is_tail)
                    begin
                        // level drains, pointers left as they are
                    end
                    else if (is_head)
                    begin
                        head_reg[cur_lvl] <= nx_rd;
                    end
                    else if (is_tail)
                    begin
                        tail_reg[cur_lvl] <= pv_rd;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
